>>> rtl/cpve_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpve_pkg
// Shared types and constants of the camera packet vector extractor.
// ----------------------------------------------------------------------------
package cpve_pkg;

    // Default cap on reported vectors per packet.
    localparam int VECTOR_LIMIT_DEF = 16;

    // Sync words and feature codes.
    localparam logic [15:0] SYNC_PLAIN      = 16'hC1AE;
    localparam logic [15:0] SYNC_CHECKED    = 16'hC1AF;
    localparam logic [7:0]  FEATURE_VECTORS = 8'h01;
    localparam logic [2:0]  VECTOR_SIZE     = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_VEC_QUOTA   = 1'b0;
    localparam logic CFG_PAYLOAD_MAX = 1'b1;

    // Configuration reset values.
    localparam logic [4:0] VEC_QUOTA_RST   = 5'd16;
    localparam logic [7:0] PAYLOAD_MAX_RST = 8'd128;

    // Result kinds and status codes.
    localparam logic       ITEM_VECTOR     = 1'b0;
    localparam logic       ITEM_END        = 1'b1;
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SYNC = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef enum logic [2:0] {
        PH_SYNC_LO,
        PH_SYNC_HI,
        PH_TYPE,
        PH_LEN,
        PH_CHK_A,
        PH_CHK_B,
        PH_PAYLOAD
    } t_frame_phase;

    typedef enum logic [1:0] {
        TLV_TYPE,
        TLV_LEN,
        TLV_DATA,
        TLV_STOP
    } t_tlv_phase;

    typedef enum logic [1:0] {
        KIND_BAD,
        KIND_PLAIN,
        KIND_CHECKED
    } t_sync_kind;

    typedef struct packed {
        logic [4:0] vec_quota;
        logic [7:0] payload_max;
    } t_cfg;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] vec_x0;
        logic [7:0] vec_y0;
        logic [7:0] vec_x1;
        logic [7:0] vec_y1;
        logic [7:0] vec_index;
        logic [7:0] vec_flags;
        logic [1:0] status;
        logic [7:0] packet_type;
        logic [7:0] payload_length;
        logic [4:0] vector_count;
        logic       last;
    } t_result;

    // Results caused by one input beat: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_step;

endpackage

>>> rtl/cpve_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpve_deframer
// Packet framing and feature parsing state, advanced once per accepted byte.
// ----------------------------------------------------------------------------
module cpve_deframer #(
    parameter int VECTOR_LIMIT = cpve_pkg::VECTOR_LIMIT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cpve_pkg::t_cfg   i_cfg,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output cpve_pkg::t_step  o_step
);

    localparam int         LIM_INT = (VECTOR_LIMIT < 31) ? VECTOR_LIMIT : 31;
    localparam logic [4:0] LIM_CAP = 5'(LIM_INT);

    cpve_pkg::t_frame_phase r_phase, n_phase;
    cpve_pkg::t_sync_kind   r_sync_kind, n_sync_kind;
    cpve_pkg::t_tlv_phase   r_tlv, n_tlv;
    logic [7:0]             r_sync_lo, n_sync_lo;
    logic [7:0]             r_type, n_type;
    logic [7:0]             r_len, n_len;
    logic [7:0]             r_left, n_left;
    logic                   r_drain, n_drain;
    logic [7:0]             r_fkind, n_fkind;
    logic [7:0]             r_fleft, n_fleft;
    logic [2:0]             r_vpos, n_vpos;
    logic [4:0]             r_emitted, n_emitted;
    logic [7:0]             r_vbytes [5];
    logic                   vbyte_we;

    logic [4:0]     limit;
    logic [15:0]    sync_word;
    logic           made_vec;
    logic           made_end;
    logic [1:0]     end_status;
    cpve_pkg::t_result vec_rec, end_rec;

    // Active vector limit.
    always_comb begin
        limit = (i_cfg.vec_quota > LIM_CAP) ? LIM_CAP : i_cfg.vec_quota;
    end

    assign sync_word = {i_rx_byte, r_sync_lo};

    // Next state for one byte.
    always_comb begin
        n_phase     = r_phase;
        n_sync_kind = r_sync_kind;
        n_tlv       = r_tlv;
        n_sync_lo   = r_sync_lo;
        n_type      = r_type;
        n_len       = r_len;
        n_left      = r_left;
        n_drain     = r_drain;
        n_fkind     = r_fkind;
        n_fleft     = r_fleft;
        n_vpos      = r_vpos;
        n_emitted   = r_emitted;
        vbyte_we    = 1'b0;
        made_vec    = 1'b0;
        made_end    = 1'b0;
        end_status  = cpve_pkg::STATUS_OK;

        unique case (r_phase)
            cpve_pkg::PH_SYNC_LO: begin
                n_sync_lo = i_rx_byte;
                n_phase   = cpve_pkg::PH_SYNC_HI;
            end
            cpve_pkg::PH_SYNC_HI: begin
                if (sync_word == cpve_pkg::SYNC_PLAIN) begin
                    n_sync_kind = cpve_pkg::KIND_PLAIN;
                end else if (sync_word == cpve_pkg::SYNC_CHECKED) begin
                    n_sync_kind = cpve_pkg::KIND_CHECKED;
                end else begin
                    n_sync_kind = cpve_pkg::KIND_BAD;
                end
                n_phase = cpve_pkg::PH_TYPE;
            end
            cpve_pkg::PH_TYPE: begin
                n_type  = i_rx_byte;
                n_phase = cpve_pkg::PH_LEN;
            end
            cpve_pkg::PH_LEN: begin
                n_len     = i_rx_byte;
                n_emitted = 5'd0;
                if (r_sync_kind == cpve_pkg::KIND_BAD) begin
                    made_end   = 1'b1;
                    end_status = cpve_pkg::STATUS_BAD_SYNC;
                    n_phase    = cpve_pkg::PH_SYNC_LO;
                end else if (r_sync_kind == cpve_pkg::KIND_CHECKED) begin
                    n_phase = cpve_pkg::PH_CHK_A;
                end else begin
                    n_phase = cpve_pkg::PH_PAYLOAD;
                end
            end
            cpve_pkg::PH_CHK_A: begin
                n_phase = cpve_pkg::PH_CHK_B;
            end
            cpve_pkg::PH_CHK_B: begin
                n_phase = cpve_pkg::PH_PAYLOAD;
            end
            cpve_pkg::PH_PAYLOAD: begin
                n_left = r_left - 8'd1;
                if (!r_drain) begin
                    unique case (r_tlv)
                        cpve_pkg::TLV_TYPE: begin
                            n_fkind = i_rx_byte;
                            n_tlv   = cpve_pkg::TLV_LEN;
                        end
                        cpve_pkg::TLV_LEN: begin
                            if (i_rx_byte > n_left) begin
                                n_tlv = cpve_pkg::TLV_STOP;
                            end else begin
                                n_fleft = i_rx_byte;
                                n_vpos  = 3'd0;
                                n_tlv   = (i_rx_byte != 8'd0) ? cpve_pkg::TLV_DATA
                                                              : cpve_pkg::TLV_TYPE;
                            end
                        end
                        cpve_pkg::TLV_DATA: begin
                            if (r_fkind == cpve_pkg::FEATURE_VECTORS) begin
                                if (r_vpos < cpve_pkg::VECTOR_SIZE - 3'd1) begin
                                    vbyte_we = 1'b1;
                                    n_vpos   = r_vpos + 3'd1;
                                end else begin
                                    if (r_emitted < limit) begin
                                        made_vec  = 1'b1;
                                        n_emitted = r_emitted + 5'd1;
                                    end
                                    n_vpos = 3'd0;
                                end
                            end
                            n_fleft = r_fleft - 8'd1;
                            if (n_fleft == 8'd0) begin
                                n_tlv = cpve_pkg::TLV_TYPE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (n_left == 8'd0) begin
                    made_end   = 1'b1;
                    end_status = r_drain ? cpve_pkg::STATUS_TOO_LONG
                                         : cpve_pkg::STATUS_OK;
                    n_phase    = cpve_pkg::PH_SYNC_LO;
                end
            end
            default: begin
                n_phase = cpve_pkg::PH_SYNC_LO;
            end
        endcase

        // Header complete: open the payload, or close an empty packet.
        if ((r_phase == cpve_pkg::PH_CHK_B) ||
            ((r_phase == cpve_pkg::PH_LEN) && (r_sync_kind == cpve_pkg::KIND_PLAIN))) begin
            n_left    = n_len;
            n_drain   = (n_len > i_cfg.payload_max);
            n_tlv     = cpve_pkg::TLV_TYPE;
            n_fkind   = 8'd0;
            n_fleft   = 8'd0;
            n_vpos    = 3'd0;
            n_emitted = 5'd0;
            if (n_len == 8'd0) begin
                made_end   = 1'b1;
                end_status = cpve_pkg::STATUS_OK;
                n_phase    = cpve_pkg::PH_SYNC_LO;
            end
        end
    end

    // Result records built from the updated state.
    always_comb begin
        vec_rec           = '0;
        vec_rec.item_kind = cpve_pkg::ITEM_VECTOR;
        vec_rec.vec_x0    = r_vbytes[0];
        vec_rec.vec_y0    = r_vbytes[1];
        vec_rec.vec_x1    = r_vbytes[2];
        vec_rec.vec_y1    = r_vbytes[3];
        vec_rec.vec_index = r_vbytes[4];
        vec_rec.vec_flags = i_rx_byte;
        vec_rec.last      = !made_end;

        end_rec                = '0;
        end_rec.item_kind      = cpve_pkg::ITEM_END;
        end_rec.status         = end_status;
        end_rec.packet_type    = n_type;
        end_rec.payload_length = n_len;
        end_rec.vector_count   = (end_status == cpve_pkg::STATUS_OK) ? n_emitted : 5'd0;
        end_rec.last           = 1'b1;

        o_step = '0;
        if (i_accept) begin
            if (made_vec) begin
                o_step.first  = vec_rec;
                o_step.second = end_rec;
                o_step.count  = made_end ? 2'd2 : 2'd1;
            end else if (made_end) begin
                o_step.first = end_rec;
                o_step.count = 2'd1;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= cpve_pkg::PH_SYNC_LO;
            r_sync_kind <= cpve_pkg::KIND_BAD;
            r_tlv       <= cpve_pkg::TLV_TYPE;
            r_sync_lo   <= 8'd0;
            r_type      <= 8'd0;
            r_len       <= 8'd0;
            r_left      <= 8'd0;
            r_drain     <= 1'b0;
            r_fkind     <= 8'd0;
            r_fleft     <= 8'd0;
            r_vpos      <= 3'd0;
            r_emitted   <= 5'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_sync_kind <= n_sync_kind;
            r_tlv       <= n_tlv;
            r_sync_lo   <= n_sync_lo;
            r_type      <= n_type;
            r_len       <= n_len;
            r_left      <= n_left;
            r_drain     <= n_drain;
            r_fkind     <= n_fkind;
            r_fleft     <= n_fleft;
            r_vpos      <= n_vpos;
            r_emitted   <= n_emitted;
        end
    end

    // Partial vector bytes; always written before they are read.
    always_ff @(posedge i_clk) begin
        if (i_accept && vbyte_we) begin
            r_vbytes[r_vpos] <= i_rx_byte;
        end
    end

endmodule

>>> rtl/cpve_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpve_result_fifo
// Four-entry result queue taking up to two records per cycle, giving at most one.
// ----------------------------------------------------------------------------
module cpve_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpve_pkg::t_step   i_push,
    input  logic              i_pop,
    output logic              o_full2,
    output logic              o_valid,
    output cpve_pkg::t_result o_head
);

    cpve_pkg::t_result r_mem [4];
    logic [1:0]        r_wr, r_rd;
    logic [2:0]        r_count;
    logic [1:0]        n_wr, n_rd;
    logic [2:0]        n_count;
    logic              pop_ok;

    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_mem[r_rd];
    assign o_full2 = (r_count > 3'd2);
    assign pop_ok  = i_pop && o_valid;

    // Pointer and fill updates.
    always_comb begin
        n_wr    = r_wr + i_push.count;
        n_rd    = r_rd + {1'b0, pop_ok};
        n_count = r_count + {1'b0, i_push.count} - {2'b00, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.second;
        end
    end

endmodule

>>> rtl/camera_packet_vector_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_packet_vector_extractor
// Deframes sync/type/length packets and reports vector features and summaries.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+---------------------------
//  in       | sink      | i_in_valid / o_in_stall | i_rx_byte
//  out      | source    | o_out_valid/i_out_stall | o_item_kind .. o_last
//  cfg      | sink      | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One byte beat is accepted per cycle unless the input stalls; its results
// enter a four-entry queue at the same edge and the head is shown from the
// next cycle. A byte causes at most two results and the output gives one per
// cycle unless stalled, so the input stalls while the queue holds more than
// two results. Synchronous reset clears all control state.
// ----------------------------------------------------------------------------
module camera_packet_vector_extractor #(
    parameter int VECTOR_LIMIT = cpve_pkg::VECTOR_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_item_kind,
    output logic [7:0] o_vec_x0,
    output logic [7:0] o_vec_y0,
    output logic [7:0] o_vec_x1,
    output logic [7:0] o_vec_y1,
    output logic [7:0] o_vec_index,
    output logic [7:0] o_vec_flags,
    output logic [1:0] o_status,
    output logic [7:0] o_packet_type,
    output logic [7:0] o_payload_length,
    output logic [4:0] o_vector_count,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    cpve_pkg::t_cfg    r_cfg;
    cpve_pkg::t_step   step;
    cpve_pkg::t_result head;
    logic              full2;
    logic              in_accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vec_quota   <= cpve_pkg::VEC_QUOTA_RST;
            r_cfg.payload_max <= cpve_pkg::PAYLOAD_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cpve_pkg::CFG_VEC_QUOTA:   r_cfg.vec_quota   <= i_cfg_data[4:0];
                cpve_pkg::CFG_PAYLOAD_MAX: r_cfg.payload_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input handshake.
    assign o_in_stall = full2;
    assign in_accept  = i_in_valid && !full2;

    cpve_deframer #(
        .VECTOR_LIMIT(VECTOR_LIMIT)
    ) u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .o_step    (step)
    );

    cpve_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_pop   (!i_out_stall),
        .o_full2 (full2),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    // Output fields from the queue head.
    assign o_item_kind      = head.item_kind;
    assign o_vec_x0         = head.vec_x0;
    assign o_vec_y0         = head.vec_y0;
    assign o_vec_x1         = head.vec_x1;
    assign o_vec_y1         = head.vec_y1;
    assign o_vec_index      = head.vec_index;
    assign o_vec_flags      = head.vec_flags;
    assign o_status         = head.status;
    assign o_packet_type    = head.packet_type;
    assign o_payload_length = head.payload_length;
    assign o_vector_count   = head.vector_count;
    assign o_last           = head.last;

endmodule

>>> verif/camera_packet_vector_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_packet_vector_extractor_tb
// Self-checking bench for the packet deframer and vector extractor.
// A byte-level predictor runs beside the block and queues the vector records
// and packet summaries each accepted byte beat should produce. The monitor
// compares every result beat field by field with the oldest prediction.
// Stimulus is a short directed set, then random packets under several
// register settings, with random idle and stall bursts on both channels and
// one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module camera_packet_vector_extractor_tb;

    localparam int          VECTOR_CAP   = cpve_pkg::VECTOR_LIMIT_DEF;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_AFTER   = 400;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          HOLD_BACKLOG = 64;

    // Block ports.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_item_kind;
    logic [7:0] o_vec_x0;
    logic [7:0] o_vec_y0;
    logic [7:0] o_vec_x1;
    logic [7:0] o_vec_y1;
    logic [7:0] o_vec_index;
    logic [7:0] o_vec_flags;
    logic [1:0] o_status;
    logic [7:0] o_packet_type;
    logic [7:0] o_payload_length;
    logic [4:0] o_vector_count;
    logic       o_last;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;

    // Byte stream waiting to be driven and records predicted from it.
    logic [7:0]        stream_bytes[$];
    cpve_pkg::t_result predicted_records[$];

    // Predictor copy of the registers and the deframer state.
    logic [4:0]             cfg_vec_quota   = cpve_pkg::VEC_QUOTA_RST;
    logic [7:0]             cfg_payload_max = cpve_pkg::PAYLOAD_MAX_RST;
    cpve_pkg::t_frame_phase fr_phase        = cpve_pkg::PH_SYNC_LO;
    cpve_pkg::t_sync_kind   fr_sync         = cpve_pkg::KIND_BAD;
    logic [7:0]             sync_lo         = 8'h00;
    logic [7:0]             hdr_type        = 8'h00;
    logic [7:0]             hdr_len         = 8'h00;
    logic [7:0]             bytes_left      = 8'h00;
    logic                   draining        = 1'b0;
    cpve_pkg::t_tlv_phase   feat_phase      = cpve_pkg::TLV_TYPE;
    logic [7:0]             feat_type       = 8'h00;
    logic [7:0]             feat_left       = 8'h00;
    logic [7:0]             vec_buf[5];
    logic [2:0]             vec_pos         = 3'd0;
    logic [4:0]             vec_count       = 5'd0;

    // Handshake pacing.
    logic              burst_stall = 1'b0;
    logic              hold_active = 1'b0;
    bit                hold_done   = 1'b0;
    bit                quiet       = 1'b0;
    int unsigned       gap_left    = 0;
    int unsigned       gap_rate    = 0;
    int unsigned       gap_epoch   = 0;
    int unsigned       burst_left  = 0;
    int unsigned       stall_rate  = 0;
    int unsigned       stall_epoch = 0;
    int unsigned       hold_cycles = 0;
    int unsigned       beat_total  = 0;
    int unsigned       cycle_count = 0;
    int unsigned       fail_count  = 0;
    cpve_pkg::t_result seen_record;

    assign i_out_stall = burst_stall | hold_active;

    camera_packet_vector_extractor #(
        .VECTOR_LIMIT(VECTOR_CAP)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_item_kind     (o_item_kind),
        .o_vec_x0        (o_vec_x0),
        .o_vec_y0        (o_vec_y0),
        .o_vec_x1        (o_vec_x1),
        .o_vec_y1        (o_vec_y1),
        .o_vec_index     (o_vec_index),
        .o_vec_flags     (o_vec_flags),
        .o_status        (o_status),
        .o_packet_type   (o_packet_type),
        .o_payload_length(o_payload_length),
        .o_vector_count  (o_vector_count),
        .o_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Summary record for the packet held in the header registers.
    function automatic cpve_pkg::t_result packet_summary(logic [1:0] status);
        cpve_pkg::t_result rec;
        rec                = '0;
        rec.item_kind      = cpve_pkg::ITEM_END;
        rec.status         = status;
        rec.packet_type    = hdr_type;
        rec.payload_length = hdr_len;
        rec.vector_count   = (status == cpve_pkg::STATUS_OK) ? vec_count : 5'd0;
        return rec;
    endfunction

    // Advance the deframer by one accepted byte and queue the records it makes.
    function automatic void deframe_byte(logic [7:0] b);
        cpve_pkg::t_result made[$];
        cpve_pkg::t_result rec;
        logic              hdr_complete;
        int unsigned       cap;
        hdr_complete = 1'b0;
        cap = (cfg_vec_quota > VECTOR_CAP) ? VECTOR_CAP : cfg_vec_quota;
        case (fr_phase)
            cpve_pkg::PH_SYNC_LO: begin
                sync_lo  = b;
                fr_phase = cpve_pkg::PH_SYNC_HI;
            end
            cpve_pkg::PH_SYNC_HI: begin
                if ({b, sync_lo} == cpve_pkg::SYNC_PLAIN) begin
                    fr_sync = cpve_pkg::KIND_PLAIN;
                end else if ({b, sync_lo} == cpve_pkg::SYNC_CHECKED) begin
                    fr_sync = cpve_pkg::KIND_CHECKED;
                end else begin
                    fr_sync = cpve_pkg::KIND_BAD;
                end
                fr_phase = cpve_pkg::PH_TYPE;
            end
            cpve_pkg::PH_TYPE: begin
                hdr_type = b;
                fr_phase = cpve_pkg::PH_LEN;
            end
            cpve_pkg::PH_LEN: begin
                hdr_len   = b;
                vec_count = 5'd0;
                if (fr_sync == cpve_pkg::KIND_BAD) begin
                    made.push_back(packet_summary(cpve_pkg::STATUS_BAD_SYNC));
                    fr_phase = cpve_pkg::PH_SYNC_LO;
                end else if (fr_sync == cpve_pkg::KIND_CHECKED) begin
                    fr_phase = cpve_pkg::PH_CHK_A;
                end else begin
                    hdr_complete = 1'b1;
                end
            end
            cpve_pkg::PH_CHK_A: begin
                fr_phase = cpve_pkg::PH_CHK_B;
            end
            cpve_pkg::PH_CHK_B: begin
                hdr_complete = 1'b1;
            end
            default: begin
                bytes_left = bytes_left - 8'd1;
                // Feature parsing, skipped entirely for an oversized payload.
                if (!draining) begin
                    case (feat_phase)
                        cpve_pkg::TLV_TYPE: begin
                            feat_type  = b;
                            feat_phase = cpve_pkg::TLV_LEN;
                        end
                        cpve_pkg::TLV_LEN: begin
                            if (b > bytes_left) begin
                                feat_phase = cpve_pkg::TLV_STOP;
                            end else begin
                                feat_left = b;
                                vec_pos   = 3'd0;
                                if (b != 8'd0) begin
                                    feat_phase = cpve_pkg::TLV_DATA;
                                end else begin
                                    feat_phase = cpve_pkg::TLV_TYPE;
                                end
                            end
                        end
                        cpve_pkg::TLV_DATA: begin
                            if (feat_type == cpve_pkg::FEATURE_VECTORS) begin
                                if (vec_pos < cpve_pkg::VECTOR_SIZE - 3'd1) begin
                                    vec_buf[vec_pos] = b;
                                    vec_pos = vec_pos + 3'd1;
                                end else begin
                                    if (vec_count < cap) begin
                                        rec           = '0;
                                        rec.item_kind = cpve_pkg::ITEM_VECTOR;
                                        rec.vec_x0    = vec_buf[0];
                                        rec.vec_y0    = vec_buf[1];
                                        rec.vec_x1    = vec_buf[2];
                                        rec.vec_y1    = vec_buf[3];
                                        rec.vec_index = vec_buf[4];
                                        rec.vec_flags = b;
                                        made.push_back(rec);
                                        vec_count = vec_count + 5'd1;
                                    end
                                    vec_pos = 3'd0;
                                end
                            end
                            feat_left = feat_left - 8'd1;
                            if (feat_left == 8'd0) begin
                                feat_phase = cpve_pkg::TLV_TYPE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (bytes_left == 8'd0) begin
                    made.push_back(packet_summary(draining ? cpve_pkg::STATUS_TOO_LONG
                                                           : cpve_pkg::STATUS_OK));
                    fr_phase = cpve_pkg::PH_SYNC_LO;
                end
            end
        endcase

        // Header complete: open the payload or close an empty packet.
        if (hdr_complete) begin
            bytes_left = hdr_len;
            draining   = (hdr_len > cfg_payload_max);
            feat_phase = cpve_pkg::TLV_TYPE;
            feat_type  = 8'h00;
            feat_left  = 8'h00;
            vec_pos    = 3'd0;
            vec_count  = 5'd0;
            if (hdr_len == 8'd0) begin
                made.push_back(packet_summary(cpve_pkg::STATUS_OK));
                fr_phase = cpve_pkg::PH_SYNC_LO;
            end else begin
                fr_phase = cpve_pkg::PH_PAYLOAD;
            end
        end

        foreach (made[k]) begin
            made[k].last = (k == made.size() - 1);
            predicted_records.push_back(made[k]);
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void compare_record(cpve_pkg::t_result want,
                                           cpve_pkg::t_result got);
        check_field("item_kind", 8'(want.item_kind), 8'(got.item_kind));
        check_field("vec_x0", want.vec_x0, got.vec_x0);
        check_field("vec_y0", want.vec_y0, got.vec_y0);
        check_field("vec_x1", want.vec_x1, got.vec_x1);
        check_field("vec_y1", want.vec_y1, got.vec_y1);
        check_field("vec_index", want.vec_index, got.vec_index);
        check_field("vec_flags", want.vec_flags, got.vec_flags);
        check_field("status", 8'(want.status), 8'(got.status));
        check_field("packet_type", want.packet_type, got.packet_type);
        check_field("payload_length", want.payload_length, got.payload_length);
        check_field("vector_count", 8'(want.vector_count), 8'(got.vector_count));
        check_field("last", 8'(want.last), 8'(got.last));
    endfunction

    // Idle rate per stretch: none, sparse or dense.
    function automatic int unsigned pick_idle_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 35;
        endcase
    endfunction

    // Data byte with extra weight on the extremes.
    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Append one random packet: mostly well formed, some bad syncs and strays.
    function automatic void add_random_packet();
        logic [7:0]  body[$];
        logic [15:0] sync;
        int unsigned roll;
        int unsigned target;
        int unsigned flen;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            repeat ($urandom_range(1, 5)) stream_bytes.push_back(random_byte());
            return;
        end
        if (roll < 12) begin
            sync = 16'($urandom_range(0, 16'hFFFF));
            if (sync[15:1] == cpve_pkg::SYNC_PLAIN[15:1]) begin
                sync[15] = ~sync[15];
            end
            stream_bytes.push_back(sync[7:0]);
            stream_bytes.push_back(sync[15:8]);
            stream_bytes.push_back(random_byte());
            stream_bytes.push_back(random_byte());
            return;
        end

        // Mostly short payloads, a few up to the largest length.
        if ($urandom_range(0, 19) == 0) begin
            target = $urandom_range(0, 255);
        end else begin
            target = $urandom_range(0, 40);
        end
        while (body.size() < target) begin
            if ($urandom_range(0, 9) < 6) begin
                flen = 6 * $urandom_range(0, 4);
                if ($urandom_range(0, 4) == 0) begin
                    flen += $urandom_range(1, 5);
                end
                body.push_back(cpve_pkg::FEATURE_VECTORS);
            end else begin
                flen = $urandom_range(0, 8);
                body.push_back(random_byte());
            end
            body.push_back(flen[7:0]);
            repeat (flen) body.push_back(random_byte());
        end
        // Cutting at the target leaves an overrun or a lone type byte.
        if (body.size() > 255 || $urandom_range(0, 1) == 0) begin
            while (body.size() > target) body.pop_back();
        end

        if ($urandom_range(0, 1) == 0) begin
            sync = cpve_pkg::SYNC_PLAIN;
        end else begin
            sync = cpve_pkg::SYNC_CHECKED;
        end
        stream_bytes.push_back(sync[7:0]);
        stream_bytes.push_back(sync[15:8]);
        stream_bytes.push_back(random_byte());
        stream_bytes.push_back(8'(body.size()));
        if (sync == cpve_pkg::SYNC_CHECKED) begin
            stream_bytes.push_back(random_byte());
            stream_bytes.push_back(random_byte());
        end
        foreach (body[k]) stream_bytes.push_back(body[k]);
    endfunction

    // Wait until every byte is taken and every record has come out.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (stream_bytes.size() != 0 || i_in_valid || predicted_records.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [4:0] quota, input logic [7:0] pay_max);
        @(posedge i_clk);
        i_cfg_we        <= 1'b1;
        i_cfg_index     <= cpve_pkg::CFG_VEC_QUOTA;
        i_cfg_data      <= {3'b000, quota};
        cfg_vec_quota   = quota;
        @(posedge i_clk);
        i_cfg_index     <= cpve_pkg::CFG_PAYLOAD_MAX;
        i_cfg_data      <= pay_max;
        cfg_payload_max = pay_max;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [4:0] quota, input logic [7:0] pay_max,
                             input int unsigned n_bytes);
        write_config(quota, pay_max);
        while (stream_bytes.size() < n_bytes) add_random_packet();
        wait_idle();
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Byte driver: offers queued bytes with random gaps between beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                deframe_byte(i_rx_byte);
                beat_total <= beat_total + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_epoch == 0) begin
                    gap_rate  = pick_idle_rate();
                    gap_epoch = 64;
                end
                gap_epoch--;
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (stream_bytes.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= stream_bytes.pop_front();
                    if (!quiet && $urandom_range(0, 99) < gap_rate) begin
                        gap_left = $urandom_range(1, 17);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Random output stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            burst_stall <= 1'b0;
        end else begin
            if (stall_epoch == 0) begin
                stall_rate  = pick_idle_rate();
                stall_epoch = 128;
            end
            stall_epoch--;
            if (burst_left != 0) begin
                burst_left--;
                burst_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < stall_rate) begin
                burst_left = $urandom_range(0, 16);
                burst_stall <= 1'b1;
            end else begin
                burst_stall <= 1'b0;
            end
        end
    end

    // One long hold-off on the output, started while plenty of bytes are
    // still queued so the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_active <= 1'b0;
        end else if (hold_active) begin
            if (hold_cycles == 0) begin
                hold_active <= 1'b0;
            end else begin
                hold_cycles--;
            end
        end else if (!hold_done && !quiet && beat_total >= HOLD_AFTER &&
                     stream_bytes.size() > HOLD_BACKLOG) begin
            hold_active <= 1'b1;
            hold_cycles = HOLD_CYCLES;
            hold_done   = 1'b1;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_record = {o_item_kind, o_vec_x0, o_vec_y0, o_vec_x1, o_vec_y1,
                           o_vec_index, o_vec_flags, o_status, o_packet_type,
                           o_payload_length, o_vector_count, o_last};
            if (predicted_records.size() == 0) begin
                $display("%0t ns: unexpected result beat, expected none, actual kind %0d",
                         $time, o_item_kind);
                fail_count++;
            end else begin
                compare_record(predicted_records.pop_front(), seen_record);
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [7:0] opening[24];
        logic [7:0] split_head[9];
        logic [7:0] split_tail[5];

        // Bad sync; checked sync with zero length; vector feature with a
        // remainder byte and a lone trailing type byte.
        opening = '{8'h00, 8'hFF, 8'hFF, 8'h7F,
                    8'hAF, 8'hC1, 8'hA5, 8'h00, 8'h12, 8'h34,
                    8'hAE, 8'hC1, 8'h01, 8'h0A, 8'h01, 8'h07,
                    8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h55, 8'h77};
        // A vector split by a register write, then a feature overrun.
        split_head = '{8'hAE, 8'hC1, 8'h33, 8'h0A, 8'h01, 8'h06, 8'h10, 8'h20, 8'h30};
        split_tail = '{8'h40, 8'h50, 8'h60, 8'h04, 8'h05};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[k]) stream_bytes.push_back(opening[k]);
        wait_idle();
        foreach (split_head[k]) stream_bytes.push_back(split_head[k]);
        wait_idle();
        write_config(5'd0, 8'd0);
        foreach (split_tail[k]) stream_bytes.push_back(split_tail[k]);
        wait_idle();

        // Random packets across register settings, extremes included.
        run_phase(5'd0, 8'd255, 90);
        run_phase(5'd1, 8'd0, 60);
        run_phase(5'd16, 8'd255, 140);
        run_phase(5'd3, 8'd40, 120);
        run_phase(5'd7, 8'd200, 90);
        quiet = 1'b1;
        run_phase(cpve_pkg::VEC_QUOTA_RST, cpve_pkg::PAYLOAD_MAX_RST, 150);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
